[hw/rtl/jsu_pkg.sv]
// jsu_pkg: shared types, character codes and the hex digit decoder for the
// JSON string unescaper. No dependencies.

package jsu_pkg;

  localparam int unsigned UnitW   = 16;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned HexRadix = 16;

  // Character codes seen in the text stream
  localparam logic [UnitW-1:0] ChQuote     = 16'h0022;
  localparam logic [UnitW-1:0] ChBackslash = 16'h005C;
  localparam logic [UnitW-1:0] ChSlash     = 16'h002F;
  localparam logic [UnitW-1:0] ChB         = 16'h0062;
  localparam logic [UnitW-1:0] ChF         = 16'h0066;
  localparam logic [UnitW-1:0] ChN         = 16'h006E;
  localparam logic [UnitW-1:0] ChR         = 16'h0072;
  localparam logic [UnitW-1:0] ChT         = 16'h0074;
  localparam logic [UnitW-1:0] ChU         = 16'h0075;
  localparam logic [UnitW-1:0] ChDigit0    = 16'h0030;
  localparam logic [UnitW-1:0] ChDigit9    = 16'h0039;
  localparam logic [UnitW-1:0] ChLowerA    = 16'h0061;
  localparam logic [UnitW-1:0] ChLowerF    = 16'h0066;
  localparam logic [UnitW-1:0] ChUpperA    = 16'h0041;
  localparam logic [UnitW-1:0] ChUpperF    = 16'h0046;

  // Control characters produced by the short escapes
  localparam logic [UnitW-1:0] CtlBackspace = 16'h0008;
  localparam logic [UnitW-1:0] CtlFormFeed  = 16'h000C;
  localparam logic [UnitW-1:0] CtlNewline   = 16'h000A;
  localparam logic [UnitW-1:0] CtlReturn    = 16'h000D;
  localparam logic [UnitW-1:0] CtlTab       = 16'h0009;

  localparam logic [UnitW-1:0] UnitZero = '0;

  // Input kinds
  localparam logic KindText = 1'b0;
  localparam logic KindEnd  = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_STR  = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX1 = 3'd3,
    PH_HEX2 = 3'd4,
    PH_HEX3 = 3'd5,
    PH_HEX4 = 3'd6
  } phase_e;

  typedef struct packed {
    logic              ok;
    logic [DigitW-1:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_digit(input logic [UnitW-1:0] u);
    hex_digit_t        r;
    logic [UnitW-1:0]  diff;
    r    = '0;
    diff = '0;
    if (u >= ChDigit0 && u <= ChDigit9) begin
      diff    = u - ChDigit0;
      r.ok    = 1'b1;
      r.value = diff[DigitW-1:0];
    end else if (u >= ChLowerA && u <= ChLowerF) begin
      diff    = u - ChLowerA + 16'd10;
      r.ok    = 1'b1;
      r.value = diff[DigitW-1:0];
    end else if (u >= ChUpperA && u <= ChUpperF) begin
      diff    = u - ChUpperA + 16'd10;
      r.ok    = 1'b1;
      r.value = diff[DigitW-1:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/json_string_unescape.sv]
// json_string_unescape: decodes a quoted JSON string one UTF-16 code unit per
// beat. Depends on jsu_pkg for phase codes, character codes and hex decoding.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+------------------------------------
//   in      | sink      | valid_i / stall_o  | kind_i, code_unit_i
//   out     | source    | valid_o / stall_i  | has_char_o, decoded_unit_o,
//           |           |                    | string_done_o, truncated_o
//
// Flow: one input beat per cycle while the output is not stalled; a beat is
// captured in the input register, decoded against the phase register in one
// short combinational step, and its result (if any) lands in the output
// register, from which it leaves on valid_o.
// Reset: rst_ni clears the valid bits of both pipeline registers and returns
// the phase to "awaiting opening quote" with the \u accumulator cleared.
// Stalls: stall_i holds a full output register; the input register then holds
// too, and stall_o rises only while the input register is full and blocked.

module json_string_unescape
  import jsu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // input channel
  input  logic             valid_i,
  output logic             stall_o,
  input  logic             kind_i,
  input  logic [UnitW-1:0] code_unit_i,
  // output channel
  output logic             valid_o,
  input  logic             stall_i,
  output logic             has_char_o,
  output logic [UnitW-1:0] decoded_unit_o,
  output logic             string_done_o,
  output logic             truncated_o
);

  // Input register
  logic             in_valid_q, in_valid_d;
  logic             kind_q;
  logic [UnitW-1:0] unit_q;

  // Decoder state
  phase_e           phase_q, phase_d;
  logic [UnitW-1:0] hex_value_q, hex_value_d;
  logic             hex_invalid_q, hex_invalid_d;

  // Output register
  logic             out_valid_q, out_valid_d;
  logic             has_char_q;
  logic [UnitW-1:0] decoded_q;
  logic             done_q;
  logic             trunc_q;

  // Result of the decode step
  logic             res_valid;
  logic             res_has_char;
  logic [UnitW-1:0] res_unit;
  logic             res_done;
  logic             res_trunc;

  logic             in_accept;
  logic             out_free;
  logic             advance;
  hex_digit_t       digit;
  logic [UnitW-1:0] hex_shifted;

  // The output register is free when empty or being drained this cycle.
  assign out_free  = !out_valid_q || !stall_i;
  // Retire the beat held in the input register into the decoder.
  assign advance   = in_valid_q && out_free;
  assign stall_o   = in_valid_q && !out_free;
  assign in_accept = valid_i && !stall_o;

  assign digit       = hex_digit(unit_q);
  assign hex_shifted = {hex_value_q[UnitW-DigitW-1:0], digit.value};

  // Decode the held beat against the current phase.
  always_comb begin
    phase_d       = phase_q;
    hex_value_d   = hex_value_q;
    hex_invalid_d = hex_invalid_q;
    res_valid     = 1'b0;
    res_has_char  = 1'b0;
    res_unit      = UnitZero;
    res_done      = 1'b0;
    res_trunc     = 1'b0;

    if (kind_q == KindEnd) begin
      // End of text: flag truncation only when inside a string.
      if (phase_q != PH_IDLE) begin
        phase_d       = PH_IDLE;
        hex_value_d   = UnitZero;
        hex_invalid_d = 1'b0;
        res_valid     = 1'b1;
        res_trunc     = 1'b1;
      end
    end else begin
      case (phase_q)
        PH_IDLE: begin
          // Skip the opening quote, whatever its value.
          phase_d = PH_STR;
        end
        PH_STR: begin
          if (unit_q == ChBackslash) begin
            phase_d = PH_ESC;
          end else if (unit_q == ChQuote) begin
            phase_d   = PH_IDLE;
            res_valid = 1'b1;
            res_done  = 1'b1;
          end else begin
            res_valid    = 1'b1;
            res_has_char = 1'b1;
            res_unit     = unit_q;
          end
        end
        PH_ESC: begin
          phase_d      = PH_STR;
          res_valid    = 1'b1;
          res_has_char = 1'b1;
          case (unit_q)
            ChQuote:     res_unit = ChQuote;
            ChBackslash: res_unit = ChBackslash;
            ChSlash:     res_unit = ChSlash;
            ChB:         res_unit = CtlBackspace;
            ChF:         res_unit = CtlFormFeed;
            ChN:         res_unit = CtlNewline;
            ChR:         res_unit = CtlReturn;
            ChT:         res_unit = CtlTab;
            ChU: begin
              phase_d       = PH_HEX1;
              hex_value_d   = UnitZero;
              hex_invalid_d = 1'b0;
              res_valid     = 1'b0;
              res_has_char  = 1'b0;
            end
            default: begin
              // Unknown escape letter: drop it silently.
              res_valid    = 1'b0;
              res_has_char = 1'b0;
            end
          endcase
        end
        PH_HEX1, PH_HEX2, PH_HEX3: begin
          if (digit.ok) begin
            hex_value_d = hex_shifted;
          end else begin
            hex_invalid_d = 1'b1;
          end
          phase_d = phase_e'(phase_q + 3'd1);
        end
        PH_HEX4: begin
          phase_d       = PH_STR;
          hex_value_d   = UnitZero;
          hex_invalid_d = 1'b0;
          res_valid     = 1'b1;
          res_has_char  = 1'b1;
          res_unit      = (hex_invalid_q || !digit.ok) ? UnitZero : hex_shifted;
        end
        default: begin
          phase_d = PH_STR;
        end
      endcase
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = res_valid;
    end else if (!stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      phase_q       <= PH_IDLE;
      hex_value_q   <= UnitZero;
      hex_invalid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        phase_q       <= phase_d;
        hex_value_q   <= hex_value_d;
        hex_invalid_q <= hex_invalid_d;
      end
    end
  end

  // Payload registers: input on acceptance, output on a valid result; else hold.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q <= kind_i;
      unit_q <= code_unit_i;
    end
    if (advance && res_valid) begin
      has_char_q <= res_has_char;
      decoded_q  <= res_unit;
      done_q     <= res_done;
      trunc_q    <= res_trunc;
    end
  end

  assign valid_o        = out_valid_q;
  assign has_char_o     = has_char_q;
  assign decoded_unit_o = decoded_q;
  assign string_done_o  = done_q;
  assign truncated_o    = trunc_q;

  // A result carries a character, a string end or a truncation, never two.
  a_result_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($countones({has_char_o, string_done_o, truncated_o}) == 1))
    else $error("result carries more than one kind of event");

  // The \u accumulator is clear whenever no hex escape is in progress.
  a_hex_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE || phase_q == PH_STR || phase_q == PH_ESC)
      |-> (hex_value_q == UnitZero && !hex_invalid_q))
    else $error("hex accumulator dirty outside a hex escape");

  // Truncation returns the decoder to awaiting an opening quote.
  a_trunc_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && kind_q == KindEnd) |=> (phase_q == PH_IDLE))
    else $error("end of text did not return to idle");

  // Input stalls only while a beat is held behind a blocked output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (in_valid_q && out_valid_q && stall_i))
    else $error("input stalled without a blocked output");

endmodule
